@@ rtl/btri_pkg.sv @@
// ----------------------------------------------------------------------------
// btri_pkg: shared types, constants and control store
// microcode word layout, operand codes and the triangulation program
// ----------------------------------------------------------------------------
package btri_pkg;

  localparam int DATA_W = 64;
  localparam int ANG_W = 40;
  localparam int CRD_W = 34;
  localparam int STEP_W = 6;

  localparam logic signed [DATA_W-1:0] Q30_PI = 64'sd3373259426;
  localparam logic signed [DATA_W-1:0] Q30_HALF_PI = 64'sd1686629713;
  localparam logic signed [DATA_W-1:0] TAN_MAX = 64'sd8388607;
  localparam int CORDIC_STEPS = 30;
  localparam int RED_STEPS = 6;

  // table register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HALF   = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  // beacon pair codes
  localparam logic [1:0] PAIR_NONE = 2'd0;
  localparam logic [1:0] PAIR_12   = 2'd1;
  localparam logic [1:0] PAIR_13   = 2'd2;
  localparam logic [1:0] PAIR_23   = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP, OP_MOV, OP_ADD, OP_SUB, OP_ABS, OP_SHL16, OP_DIV16, OP_CSGN,
    OP_MUL, OP_DIV, OP_TAN, OP_TANS, OP_FIN_HOLD, OP_FIN_UPD
  } op_t;

  typedef enum logic [4:0] {
    S_ZERO, S_T1, S_T2, S_T3, S_TQ, S_TMP, S_NUM, S_DEN, S_Y, S_P,
    S_CX, S_CY, S_ANG1, S_ANG2, S_ANG3, S_W, S_H, S_L16
  } src_t;

  typedef enum logic [3:0] {
    D_NONE, D_T1, D_T2, D_T3, D_TQ, D_TMP, D_NUM, D_DEN, D_Y, D_X, D_P
  } dst_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_ZERO, C_LE0, C_GT_TANMAX, C_GT_HALFPI, C_PAIR1, C_PAIR2, C_PAIR3
  } cond_t;

  typedef enum logic [1:0] {J_NEXT, J_JMP, J_CALL, J_RET} jump_t;

  typedef struct packed {
    op_t               op;
    src_t              a;
    src_t              b;
    dst_t              dst;
    cond_t             cond;
    jump_t             jk;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic hold;
    logic take;
  } seq_ctl_t;

  // program labels
  localparam logic [STEP_W-1:0] L_FAULT = 6'd3;
  localparam logic [STEP_W-1:0] L_TP    = 6'd4;
  localparam logic [STEP_W-1:0] L_P1    = 6'd10;
  localparam logic [STEP_W-1:0] L_P2    = 6'd23;
  localparam logic [STEP_W-1:0] L_P2B   = 6'd33;
  localparam logic [STEP_W-1:0] L_P2Y   = 6'd40;
  localparam logic [STEP_W-1:0] L_P3    = 6'd46;
  localparam logic [STEP_W-1:0] L_P3B   = 6'd54;
  localparam logic [STEP_W-1:0] L_P3Y   = 6'd59;
  localparam logic [STEP_W-1:0] L_NONE  = 6'd0;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd66950223;
      5'd5:  v = 30'd33500471;
      5'd6:  v = 30'd16753408;
      5'd7:  v = 30'd8378026;
      5'd8:  v = 30'd4189559;
      5'd9:  v = 30'd2094858;
      5'd10: v = 30'd1047436;
      5'd11: v = 30'd523719;
      5'd12: v = 30'd261860;
      5'd13: v = 30'd130930;
      5'd14: v = 30'd65465;
      5'd15: v = 30'd32733;
      5'd16: v = 30'd16366;
      5'd17: v = 30'd8183;
      5'd18: v = 30'd4091;
      5'd19: v = 30'd2045;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic ucode_t mk(input op_t op, input src_t a, input src_t b,
                                input dst_t d, input cond_t c, input jump_t j,
                                input logic [STEP_W-1:0] t);
    ucode_t w;
    w.op = op;
    w.a = a;
    w.b = b;
    w.dst = d;
    w.cond = c;
    w.jk = j;
    w.target = t;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      // dispatch on the beacon pair
      6'd0:  w = mk(OP_NOP, S_ZERO, S_ZERO, D_NONE, C_PAIR1, J_JMP, L_P1);
      6'd1:  w = mk(OP_NOP, S_ZERO, S_ZERO, D_NONE, C_PAIR2, J_JMP, L_P2);
      6'd2:  w = mk(OP_NOP, S_ZERO, S_ZERO, D_NONE, C_PAIR3, J_JMP, L_P3);
      6'd3:  w = mk(OP_FIN_HOLD, S_ZERO, S_ZERO, D_NONE, C_ALWAYS, J_NEXT, L_NONE);
      // tangent post: tq = sign(cy) * (|cy| << 16) / cx
      6'd4:  w = mk(OP_NOP, S_CX, S_ZERO, D_NONE, C_LE0, J_JMP, L_FAULT);
      6'd5:  w = mk(OP_ABS, S_CY, S_ZERO, D_TMP, C_ALWAYS, J_NEXT, L_NONE);
      6'd6:  w = mk(OP_SHL16, S_TMP, S_ZERO, D_TMP, C_ALWAYS, J_NEXT, L_NONE);
      6'd7:  w = mk(OP_DIV, S_TMP, S_CX, D_TQ, C_ALWAYS, J_NEXT, L_NONE);
      6'd8:  w = mk(OP_NOP, S_TQ, S_ZERO, D_NONE, C_GT_TANMAX, J_JMP, L_FAULT);
      6'd9:  w = mk(OP_CSGN, S_TQ, S_CY, D_TQ, C_ALWAYS, J_RET, L_NONE);
      // pair 1-2
      6'd10: w = mk(OP_TAN, S_ANG1, S_ZERO, D_NONE, C_ALWAYS, J_CALL, L_TP);
      6'd11: w = mk(OP_MOV, S_TQ, S_ZERO, D_T1, C_ALWAYS, J_NEXT, L_NONE);
      6'd12: w = mk(OP_TAN, S_ANG2, S_ZERO, D_NONE, C_ALWAYS, J_CALL, L_TP);
      6'd13: w = mk(OP_MOV, S_TQ, S_ZERO, D_T2, C_ALWAYS, J_NEXT, L_NONE);
      6'd14: w = mk(OP_ADD, S_T2, S_T1, D_DEN, C_ALWAYS, J_NEXT, L_NONE);
      6'd15: w = mk(OP_NOP, S_DEN, S_ZERO, D_NONE, C_ZERO, J_JMP, L_FAULT);
      6'd16: w = mk(OP_MUL, S_W, S_T2, D_P, C_ALWAYS, J_NEXT, L_NONE);
      6'd17: w = mk(OP_MUL, S_P, S_T1, D_P, C_ALWAYS, J_NEXT, L_NONE);
      6'd18: w = mk(OP_SHL16, S_DEN, S_ZERO, D_TMP, C_ALWAYS, J_NEXT, L_NONE);
      6'd19: w = mk(OP_DIV, S_P, S_TMP, D_X, C_ALWAYS, J_NEXT, L_NONE);
      6'd20: w = mk(OP_MUL, S_W, S_T1, D_P, C_ALWAYS, J_NEXT, L_NONE);
      6'd21: w = mk(OP_DIV, S_P, S_DEN, D_Y, C_ALWAYS, J_NEXT, L_NONE);
      6'd22: w = mk(OP_FIN_UPD, S_ZERO, S_ZERO, D_NONE, C_ALWAYS, J_NEXT, L_NONE);
      // pair 1-3
      6'd23: w = mk(OP_TAN, S_ANG1, S_ZERO, D_NONE, C_ALWAYS, J_CALL, L_TP);
      6'd24: w = mk(OP_MOV, S_TQ, S_ZERO, D_T1, C_ALWAYS, J_NEXT, L_NONE);
      6'd25: w = mk(OP_NOP, S_ANG3, S_ZERO, D_NONE, C_GT_HALFPI, J_JMP, L_P2B);
      6'd26: w = mk(OP_TAN, S_ANG3, S_ZERO, D_NONE, C_ALWAYS, J_CALL, L_TP);
      6'd27: w = mk(OP_MOV, S_TQ, S_ZERO, D_T3, C_ALWAYS, J_NEXT, L_NONE);
      6'd28: w = mk(OP_MUL, S_H, S_T3, D_P, C_ALWAYS, J_NEXT, L_NONE);
      6'd29: w = mk(OP_MUL, S_W, S_T1, D_TMP, C_ALWAYS, J_NEXT, L_NONE);
      6'd30: w = mk(OP_ADD, S_P, S_TMP, D_NUM, C_ALWAYS, J_NEXT, L_NONE);
      6'd31: w = mk(OP_SUB, S_NUM, S_L16, D_NUM, C_ALWAYS, J_NEXT, L_NONE);
      6'd32: w = mk(OP_ADD, S_T1, S_T3, D_DEN, C_ALWAYS, J_JMP, L_P2Y);
      6'd33: w = mk(OP_TANS, S_ANG3, S_ZERO, D_NONE, C_ALWAYS, J_CALL, L_TP);
      6'd34: w = mk(OP_MOV, S_TQ, S_ZERO, D_T3, C_ALWAYS, J_NEXT, L_NONE);
      6'd35: w = mk(OP_MUL, S_H, S_T3, D_P, C_ALWAYS, J_NEXT, L_NONE);
      6'd36: w = mk(OP_MUL, S_W, S_T1, D_TMP, C_ALWAYS, J_NEXT, L_NONE);
      6'd37: w = mk(OP_SUB, S_P, S_TMP, D_NUM, C_ALWAYS, J_NEXT, L_NONE);
      6'd38: w = mk(OP_ADD, S_NUM, S_L16, D_NUM, C_ALWAYS, J_NEXT, L_NONE);
      6'd39: w = mk(OP_SUB, S_T3, S_T1, D_DEN, C_ALWAYS, J_NEXT, L_NONE);
      6'd40: w = mk(OP_NOP, S_DEN, S_ZERO, D_NONE, C_ZERO, J_JMP, L_FAULT);
      6'd41: w = mk(OP_DIV, S_NUM, S_DEN, D_Y, C_ALWAYS, J_NEXT, L_NONE);
      6'd42: w = mk(OP_SUB, S_W, S_Y, D_TMP, C_ALWAYS, J_NEXT, L_NONE);
      6'd43: w = mk(OP_MUL, S_TMP, S_T1, D_P, C_ALWAYS, J_NEXT, L_NONE);
      6'd44: w = mk(OP_DIV16, S_P, S_ZERO, D_X, C_ALWAYS, J_NEXT, L_NONE);
      6'd45: w = mk(OP_FIN_UPD, S_ZERO, S_ZERO, D_NONE, C_ALWAYS, J_NEXT, L_NONE);
      // pair 2-3
      6'd46: w = mk(OP_TAN, S_ANG2, S_ZERO, D_NONE, C_ALWAYS, J_CALL, L_TP);
      6'd47: w = mk(OP_MOV, S_TQ, S_ZERO, D_T2, C_ALWAYS, J_NEXT, L_NONE);
      6'd48: w = mk(OP_NOP, S_ANG3, S_ZERO, D_NONE, C_GT_HALFPI, J_JMP, L_P3B);
      6'd49: w = mk(OP_TAN, S_ANG3, S_ZERO, D_NONE, C_ALWAYS, J_CALL, L_TP);
      6'd50: w = mk(OP_MOV, S_TQ, S_ZERO, D_T3, C_ALWAYS, J_NEXT, L_NONE);
      6'd51: w = mk(OP_MUL, S_H, S_T3, D_P, C_ALWAYS, J_NEXT, L_NONE);
      6'd52: w = mk(OP_SUB, S_P, S_L16, D_NUM, C_ALWAYS, J_NEXT, L_NONE);
      6'd53: w = mk(OP_SUB, S_T3, S_T2, D_DEN, C_ALWAYS, J_JMP, L_P3Y);
      6'd54: w = mk(OP_TANS, S_ANG3, S_ZERO, D_NONE, C_ALWAYS, J_CALL, L_TP);
      6'd55: w = mk(OP_MOV, S_TQ, S_ZERO, D_T3, C_ALWAYS, J_NEXT, L_NONE);
      6'd56: w = mk(OP_MUL, S_H, S_T3, D_P, C_ALWAYS, J_NEXT, L_NONE);
      6'd57: w = mk(OP_ADD, S_P, S_L16, D_NUM, C_ALWAYS, J_NEXT, L_NONE);
      6'd58: w = mk(OP_ADD, S_T2, S_T3, D_DEN, C_ALWAYS, J_NEXT, L_NONE);
      6'd59: w = mk(OP_NOP, S_DEN, S_ZERO, D_NONE, C_ZERO, J_JMP, L_FAULT);
      6'd60: w = mk(OP_DIV, S_NUM, S_DEN, D_Y, C_ALWAYS, J_NEXT, L_NONE);
      6'd61: w = mk(OP_MUL, S_T2, S_Y, D_P, C_ALWAYS, J_NEXT, L_NONE);
      6'd62: w = mk(OP_DIV16, S_P, S_ZERO, D_X, C_ALWAYS, J_NEXT, L_NONE);
      6'd63: w = mk(OP_FIN_UPD, S_ZERO, S_ZERO, D_NONE, C_ALWAYS, J_NEXT, L_NONE);
      default: w = mk(OP_FIN_HOLD, S_ZERO, S_ZERO, D_NONE, C_ALWAYS, J_NEXT, L_NONE);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/beacon_pair_triangulation.sv @@
// ----------------------------------------------------------------------------
// beacon_pair_triangulation: opponent position from two beacon bearings
// microcoded datapath with cordic tangent and bit-serial multiply/divide
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid/in_ready): one beat carries beacon_id and
//   bearing_angle; the bearing is stored and the last two distinct beacons
//   pick the triangulation formula
// - output channel (out_valid/out_ready): exactly one beat per input beat,
//   with the held position, the update and fault flags and the pair code
// - config port: cfg_we writes cfg_data into register cfg_index at once
//   (0 table width, 1 half width, 2 length); other indexes are ignored
// - timing: a beat that forms no pair runs only the dispatch steps; a full
//   triangulation takes longer, less when a tangent or a divisor faults, and
//   is set by the bit-serial divider (three or four quotients per item), the
//   cordic tangent and the shift-add multiplier
// - one item at a time: in_ready is high whenever the sequencer is idle, even
//   while the last result still waits in the output register
// - a stalled receiver holds the finished result; the sequencer waits on its
//   final step until the output register frees
// - reset: synchronous; clears the table registers to 2000/1000/3000, the
//   stored bearings, the beacon history and the held position
// ----------------------------------------------------------------------------
module beacon_pair_triangulation #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         beacon_id,
  input  logic [14:0]        bearing_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] x_position,
  output logic signed [15:0] y_position,
  output logic               position_updated,
  output logic [1:0]         pair_code,
  output logic               math_fault,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);

  localparam int DW = btri_pkg::DATA_W;
  localparam int Q30_SHIFT = 30 - ANGLE_FRAC_BITS;

  // table registers
  logic [12:0] tbl_w;
  logic [12:0] tbl_h;
  logic [12:0] tbl_l;

  // bearing store and beacon history
  logic [14:0] ang1;
  logic [14:0] ang2;
  logic [14:0] ang3;
  logic [1:0]  last_beacon;
  logic [1:0]  previous_beacon;
  logic [1:0]  previous_next;
  logic [1:0]  pair;
  logic [1:0]  pair_next;

  // datapath registers
  logic signed [DW-1:0] t1, t2, t3, tq, tmp, num, den, yv, xv, pv;

  logic signed [DW-1:0] a_val;
  logic signed [DW-1:0] b_val;
  logic signed [DW-1:0] alu;
  logic signed [DW-1:0] wr_val;
  logic                 take;
  logic                 is_md;
  logic                 is_tan;
  logic                 is_fin;
  logic                 launched;
  logic                 unit_done;
  logic                 hold;
  logic                 advance;
  logic                 fin_fire;
  logic                 in_fire;

  btri_pkg::ucode_t   word;
  btri_pkg::seq_ctl_t ctl;
  logic               running;

  logic                 md_done;
  logic signed [DW-1:0] md_result;
  logic                 tan_done;
  logic signed [btri_pkg::CRD_W-1:0] cx;
  logic signed [btri_pkg::CRD_W-1:0] cy;

  function automatic logic [1:0] decode_pair(input logic [1:0] p, input logic [1:0] q);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [1:0] code;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    case ({lo, hi})
      4'b0110: code = btri_pkg::PAIR_12;
      4'b0111: code = btri_pkg::PAIR_13;
      4'b1011: code = btri_pkg::PAIR_23;
      default: code = btri_pkg::PAIR_NONE;
    endcase
    return code;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [DW-1:0] v);
    logic signed [15:0] s;
    if (v > 64'sd32767) begin
      s = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      s = -16'sh8000;
    end else begin
      s = v[15:0];
    end
    return s;
  endfunction

  function automatic logic signed [DW-1:0] to_q30(input logic [14:0] a);
    return signed'(DW'(a) << Q30_SHIFT);
  endfunction

  function automatic logic signed [DW-1:0] pick(
    input btri_pkg::src_t s,
    input logic signed [DW-1:0] v_t1, input logic signed [DW-1:0] v_t2,
    input logic signed [DW-1:0] v_t3, input logic signed [DW-1:0] v_tq,
    input logic signed [DW-1:0] v_tmp, input logic signed [DW-1:0] v_num,
    input logic signed [DW-1:0] v_den, input logic signed [DW-1:0] v_y,
    input logic signed [DW-1:0] v_p, input logic signed [DW-1:0] v_cx,
    input logic signed [DW-1:0] v_cy, input logic signed [DW-1:0] v_a1,
    input logic signed [DW-1:0] v_a2, input logic signed [DW-1:0] v_a3,
    input logic signed [DW-1:0] v_w, input logic signed [DW-1:0] v_h,
    input logic signed [DW-1:0] v_l16);
    logic signed [DW-1:0] v;
    case (s)
      btri_pkg::S_T1:   v = v_t1;
      btri_pkg::S_T2:   v = v_t2;
      btri_pkg::S_T3:   v = v_t3;
      btri_pkg::S_TQ:   v = v_tq;
      btri_pkg::S_TMP:  v = v_tmp;
      btri_pkg::S_NUM:  v = v_num;
      btri_pkg::S_DEN:  v = v_den;
      btri_pkg::S_Y:    v = v_y;
      btri_pkg::S_P:    v = v_p;
      btri_pkg::S_CX:   v = v_cx;
      btri_pkg::S_CY:   v = v_cy;
      btri_pkg::S_ANG1: v = v_a1;
      btri_pkg::S_ANG2: v = v_a2;
      btri_pkg::S_ANG3: v = v_a3;
      btri_pkg::S_W:    v = v_w;
      btri_pkg::S_H:    v = v_h;
      btri_pkg::S_L16:  v = v_l16;
      default:          v = '0;
    endcase
    return v;
  endfunction

  logic signed [DW-1:0] cx_w, cy_w, a1_w, a2_w, a3_w, w_w, h_w, l16_w;

  assign cx_w  = DW'(cx);
  assign cy_w  = DW'(cy);
  assign a1_w  = to_q30(ang1);
  assign a2_w  = to_q30(ang2);
  assign a3_w  = to_q30(ang3);
  assign w_w   = signed'(DW'(tbl_w));
  assign h_w   = signed'(DW'(tbl_h));
  assign l16_w = signed'(DW'(tbl_l) << 16);

  always_comb begin
    a_val = pick(word.a, t1, t2, t3, tq, tmp, num, den, yv, pv, cx_w, cy_w,
                 a1_w, a2_w, a3_w, w_w, h_w, l16_w);
    b_val = pick(word.b, t1, t2, t3, tq, tmp, num, den, yv, pv, cx_w, cy_w,
                 a1_w, a2_w, a3_w, w_w, h_w, l16_w);
  end

  // combinational alu
  always_comb begin
    case (word.op)
      btri_pkg::OP_ADD:   alu = a_val + b_val;
      btri_pkg::OP_SUB:   alu = a_val - b_val;
      btri_pkg::OP_ABS:   alu = (a_val < 0) ? -a_val : a_val;
      btri_pkg::OP_SHL16: alu = a_val <<< 16;
      // truncate toward zero when dividing by 2^16
      btri_pkg::OP_DIV16: alu = (a_val + ((a_val < 0) ? 64'sd65535 : 64'sd0)) >>> 16;
      btri_pkg::OP_CSGN:  alu = (b_val < 0) ? -a_val : a_val;
      default:            alu = a_val;
    endcase
  end

  // jump conditions look at operand a or the pair code
  always_comb begin
    case (word.cond)
      btri_pkg::C_ZERO:      take = (a_val == '0);
      btri_pkg::C_LE0:       take = (a_val <= 0);
      btri_pkg::C_GT_TANMAX: take = (a_val > btri_pkg::TAN_MAX);
      btri_pkg::C_GT_HALFPI: take = (a_val > btri_pkg::Q30_HALF_PI);
      btri_pkg::C_PAIR1:     take = (pair == btri_pkg::PAIR_12);
      btri_pkg::C_PAIR2:     take = (pair == btri_pkg::PAIR_13);
      btri_pkg::C_PAIR3:     take = (pair == btri_pkg::PAIR_23);
      default:               take = 1'b1;
    endcase
  end

  assign is_md  = (word.op == btri_pkg::OP_MUL) || (word.op == btri_pkg::OP_DIV);
  assign is_tan = (word.op == btri_pkg::OP_TAN) || (word.op == btri_pkg::OP_TANS);
  assign is_fin = (word.op == btri_pkg::OP_FIN_HOLD) || (word.op == btri_pkg::OP_FIN_UPD);
  assign unit_done = is_md ? md_done : tan_done;

  // multiply, divide and tangent steps wait for their unit; the final step waits for the output slot
  assign hold = ((is_md || is_tan) && !(launched && unit_done)) ||
                (is_fin && out_valid && !out_ready);
  assign advance  = running && !hold;
  assign fin_fire = advance && is_fin;
  assign in_ready = !running;
  assign in_fire  = in_valid && in_ready;
  assign wr_val   = is_md ? md_result : alu;

  assign ctl.start = in_fire;
  assign ctl.hold  = hold;
  assign ctl.take  = take;

  btri_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .word    (word),
    .running (running)
  );

  btri_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (running && is_md && !launched),
    .is_div (word.op == btri_pkg::OP_DIV),
    .a      (a_val),
    .b      (b_val),
    .done   (md_done),
    .result (md_result)
  );

  btri_tan u_tan (
    .clk   (clk),
    .rst   (rst),
    .start (running && is_tan && !launched),
    .supp  (word.op == btri_pkg::OP_TANS),
    .angle (a_val[btri_pkg::ANG_W-1:0]),
    .done  (tan_done),
    .x_out (cx),
    .y_out (cy)
  );

  // unit launch tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
    end else if (running && (is_md || is_tan)) begin
      launched <= !(launched && unit_done);
    end
  end

  // datapath register writes
  always_ff @(posedge clk) begin
    if (advance && !is_tan) begin
      case (word.dst)
        btri_pkg::D_T1:  t1 <= wr_val;
        btri_pkg::D_T2:  t2 <= wr_val;
        btri_pkg::D_T3:  t3 <= wr_val;
        btri_pkg::D_TQ:  tq <= wr_val;
        btri_pkg::D_TMP: tmp <= wr_val;
        btri_pkg::D_NUM: num <= wr_val;
        btri_pkg::D_DEN: den <= wr_val;
        btri_pkg::D_Y:   yv <= wr_val;
        btri_pkg::D_X:   xv <= wr_val;
        btri_pkg::D_P:   pv <= wr_val;
        default: begin
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_w <= 13'd2000;
      tbl_h <= 13'd1000;
      tbl_l <= 13'd3000;
    end else if (cfg_we) begin
      case (cfg_index)
        btri_pkg::REG_WIDTH:  tbl_w <= cfg_data;
        btri_pkg::REG_HALF:   tbl_h <= cfg_data;
        btri_pkg::REG_LENGTH: tbl_l <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // bearing store and pair tracking on each input beat
  assign previous_next = (beacon_id != last_beacon) ? last_beacon : previous_beacon;
  assign pair_next = decode_pair(previous_next, beacon_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      ang1 <= '0;
      ang2 <= '0;
      ang3 <= '0;
      last_beacon <= '0;
      previous_beacon <= '0;
      pair <= btri_pkg::PAIR_NONE;
    end else if (in_fire) begin
      previous_beacon <= previous_next;
      last_beacon <= beacon_id;
      pair <= pair_next;
      case (beacon_id)
        2'd1: ang1 <= bearing_angle;
        2'd2: ang2 <= bearing_angle;
        2'd3: ang3 <= bearing_angle;
        default: begin
        end
      endcase
    end
  end

  // output register, position held between updates
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      x_position <= '0;
      y_position <= '0;
      position_updated <= 1'b0;
      pair_code <= btri_pkg::PAIR_NONE;
      math_fault <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
      pair_code <= pair;
      if (word.op == btri_pkg::OP_FIN_UPD) begin
        x_position <= sat16(xv);
        y_position <= sat16(yv);
        position_updated <= 1'b1;
        math_fault <= 1'b0;
      end else begin
        position_updated <= 1'b0;
        math_fault <= (pair != btri_pkg::PAIR_NONE);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  a_upd_xor_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(position_updated && math_fault))
    else $error("update and fault reported together");

  a_no_pair_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (pair_code == btri_pkg::PAIR_NONE)) |-> (!position_updated && !math_fault))
    else $error("flags set without a beacon pair");

  a_hold_position: assert property (@(posedge clk) disable iff (rst)
    (fin_fire && (word.op == btri_pkg::OP_FIN_HOLD)) |=>
      ($stable(x_position) && $stable(y_position)))
    else $error("position changed on a result without update");

  a_result_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(fin_fire))
    else $error("result beat raised outside the final step");

endmodule

@@ rtl/btri_seq.sv @@
// ----------------------------------------------------------------------------
// btri_seq: microcode sequencer
// step counter, one-level return register and control store lookup
// ----------------------------------------------------------------------------
module btri_seq (
  input  logic              clk,
  input  logic              rst,
  input  btri_pkg::seq_ctl_t ctl,
  output btri_pkg::ucode_t  word,
  output logic              running
);

  logic [btri_pkg::STEP_W-1:0] step;
  logic [btri_pkg::STEP_W-1:0] ret;
  logic [btri_pkg::STEP_W-1:0] step_inc;
  logic                        is_fin;

  assign word = btri_pkg::ucode_rom(step);
  assign step_inc = step + 1'b1;
  assign is_fin = (word.op == btri_pkg::OP_FIN_HOLD) || (word.op == btri_pkg::OP_FIN_UPD);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step <= '0;
      ret <= '0;
    end else if (ctl.start) begin
      running <= 1'b1;
      step <= '0;
    end else if (running && !ctl.hold) begin
      if (is_fin) begin
        running <= 1'b0;
      end else begin
        unique case (word.jk)
          btri_pkg::J_JMP: begin
            step <= ctl.take ? word.target : step_inc;
          end
          btri_pkg::J_CALL: begin
            if (ctl.take) begin
              ret <= step_inc;
              step <= word.target;
            end else begin
              step <= step_inc;
            end
          end
          btri_pkg::J_RET: begin
            step <= ctl.take ? ret : step_inc;
          end
          default: begin
            step <= step_inc;
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/btri_tan.sv @@
// ----------------------------------------------------------------------------
// btri_tan: angle reduction and rotation-mode cordic
// reduces a q30 angle modulo pi, then 30 rotations from (2^30, 0)
// ----------------------------------------------------------------------------
module btri_tan (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                supp,
  input  logic [btri_pkg::ANG_W-1:0]          angle,
  output logic                                done,
  output logic signed [btri_pkg::CRD_W-1:0]   x_out,
  output logic signed [btri_pkg::CRD_W-1:0]   y_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RED  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_ROT  = 2'd3;

  localparam logic signed [btri_pkg::ANG_W-1:0] PI_A =
    btri_pkg::ANG_W'(btri_pkg::Q30_PI);
  localparam logic signed [btri_pkg::ANG_W-1:0] HALF_A =
    btri_pkg::ANG_W'(btri_pkg::Q30_HALF_PI);

  logic [1:0]                              state;
  logic [4:0]                              cnt;
  logic                                    supp_q;
  logic signed [btri_pkg::ANG_W-1:0]       r;
  logic signed [btri_pkg::ANG_W-1:0]       pk;
  logic signed [btri_pkg::ANG_W-1:0]       rr;
  logic signed [btri_pkg::CRD_W-1:0]       dx;
  logic signed [btri_pkg::CRD_W-1:0]       dy;
  logic signed [btri_pkg::ANG_W-1:0]       at;

  always_comb begin
    pk = PI_A <<< cnt[2:0];
    rr = (supp_q && (r != '0)) ? (PI_A - r) : r;
    if (rr > HALF_A) begin
      rr = rr - PI_A;
    end
    dx = y_out >>> cnt;
    dy = x_out >>> cnt;
    at = btri_pkg::ANG_W'(btri_pkg::atan_q30(cnt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            r <= signed'(angle);
            supp_q <= supp;
            cnt <= 5'(btri_pkg::RED_STEPS - 1);
            state <= ST_RED;
          end
        end
        ST_RED: begin
          // restoring subtraction of pi << k
          if (r >= pk) begin
            r <= r - pk;
          end
          if (cnt == 5'd0) begin
            state <= ST_FIX;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_FIX: begin
          r <= rr;
          x_out <= btri_pkg::CRD_W'(64'sd1073741824);
          y_out <= '0;
          cnt <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          if (r >= 0) begin
            x_out <= x_out - dx;
            y_out <= y_out + dy;
            r <= r - at;
          end else begin
            x_out <= x_out + dx;
            y_out <= y_out - dy;
            r <= r + at;
          end
          if (cnt == 5'(btri_pkg::CORDIC_STEPS - 1)) begin
            state <= ST_IDLE;
            done <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/btri_muldiv.sv @@
// ----------------------------------------------------------------------------
// btri_muldiv: bit-serial signed multiplier and divider
// shift-add multiply that stops when the multiplier runs out, restoring divide
// ----------------------------------------------------------------------------
module btri_muldiv (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                is_div,
  input  logic signed [btri_pkg::DATA_W-1:0]  a,
  input  logic signed [btri_pkg::DATA_W-1:0]  b,
  output logic                                done,
  output logic signed [btri_pkg::DATA_W-1:0]  result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  localparam int CNT_W = $clog2(btri_pkg::DATA_W);

  logic [1:0]                    state;
  logic [CNT_W-1:0]              cnt;
  logic                          neg;
  logic [btri_pkg::DATA_W-1:0]   ma;
  logic [btri_pkg::DATA_W-1:0]   mb;
  logic [btri_pkg::DATA_W-1:0]   acc;
  logic [btri_pkg::DATA_W-1:0]   shifted;
  logic [btri_pkg::DATA_W-1:0]   quo_next;
  logic [btri_pkg::DATA_W-1:0]   rem_next;

  always_comb begin
    shifted = {acc[btri_pkg::DATA_W-2:0], ma[btri_pkg::DATA_W-1]};
    if (shifted >= mb) begin
      rem_next = shifted - mb;
      quo_next = {ma[btri_pkg::DATA_W-2:0], 1'b1};
    end else begin
      rem_next = shifted;
      quo_next = {ma[btri_pkg::DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            ma <= a[btri_pkg::DATA_W-1] ? -a : a;
            mb <= b[btri_pkg::DATA_W-1] ? -b : b;
            neg <= a[btri_pkg::DATA_W-1] ^ b[btri_pkg::DATA_W-1];
            acc <= '0;
            cnt <= '0;
            state <= is_div ? ST_DIV : ST_MUL;
          end
        end
        ST_MUL: begin
          if (mb == '0) begin
            result <= neg ? -signed'(acc) : signed'(acc);
            done <= 1'b1;
            state <= ST_IDLE;
          end else begin
            if (mb[0]) begin
              acc <= acc + ma;
            end
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end
        ST_DIV: begin
          // ma holds the dividend shifting into the quotient, acc the remainder
          acc <= rem_next;
          ma <= quo_next;
          if (cnt == CNT_W'(btri_pkg::DATA_W - 1)) begin
            result <= neg ? -signed'(quo_next) : signed'(quo_next);
            done <= 1'b1;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sim/beacon_pair_triangulation_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_pair_triangulation_check: position predictor and result checker
// watches the bearing and position channels and the table register port,
// predicts each position beat and compares it field by field
// ----------------------------------------------------------------------------
module beacon_pair_triangulation_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         beacon_id,
  input  logic [14:0]        bearing_angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] x_position,
  input  logic signed [15:0] y_position,
  input  logic               position_updated,
  input  logic [1:0]         pair_code,
  input  logic               math_fault,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int FRAC_BITS = 13;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               upd;
    logic [1:0]         pair;
    logic               fault;
  } fix_t;

  longint arc_tab [30] = '{
    843314857, 497837829, 263043836, 133525158, 66950223, 33500471,
    16753408, 8378026, 4189559, 2094858, 1047436, 523719, 261860,
    130930, 65465, 32733, 16366, 8183, 4091, 2045, 1023, 511, 255,
    127, 63, 31, 15, 7, 3, 1};

  fix_t               fix_q[$];
  logic [14:0]        bearings [4];
  logic [1:0]         last_id, prev_id;
  logic signed [15:0] held_x, held_y;
  logic [12:0]        tab_w, tab_h, tab_l;

  function automatic longint q30_of(input logic [14:0] a);
    return longint'({49'd0, a}) <<< (30 - FRAC_BITS);
  endfunction

  // cordic tangent in q8.16, flags overflow near pi/2
  function automatic longint tangent(input longint a, inout bit bad);
    longint r, cx, cy, dx, dy, mag, q;
    r = a % longint'(btri_pkg::Q30_PI);
    if (r < 0) r += longint'(btri_pkg::Q30_PI);
    if (r > longint'(btri_pkg::Q30_HALF_PI)) r -= longint'(btri_pkg::Q30_PI);
    cx = 64'sd1 <<< 30;
    cy = 0;
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (r >= 0) begin
        cx -= dx; cy += dy; r -= arc_tab[i];
      end else begin
        cx += dx; cy -= dy; r += arc_tab[i];
      end
    end
    if (cx <= 0) begin
      bad = 1;
      return 0;
    end
    mag = cy < 0 ? -cy : cy;
    q = (mag <<< 16) / cx;
    if (q > longint'(btri_pkg::TAN_MAX)) begin
      bad = 1;
      return 0;
    end
    return cy < 0 ? -q : q;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [1:0] pair_of(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] lo, hi;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    if (lo == 2'd1 && hi == 2'd2) return btri_pkg::PAIR_12;
    if (lo == 2'd1 && hi == 2'd3) return btri_pkg::PAIR_13;
    if (lo == 2'd2 && hi == 2'd3) return btri_pkg::PAIR_23;
    return btri_pkg::PAIR_NONE;
  endfunction

  task automatic triangulate(input logic [1:0] id, input logic [14:0] ang);
    fix_t   f;
    bit     bad, upd;
    longint w, h, l16, px, py, t1, t2, t3, a3, den, num;
    bad = 0;
    upd = 0;
    px = 0;
    py = 0;
    w = longint'(tab_w);
    h = longint'(tab_h);
    l16 = longint'(tab_l) * 65536;
    if (id != last_id) prev_id = last_id;
    last_id = id;
    bearings[id] = ang;
    f.pair = pair_of(prev_id, last_id);
    a3 = q30_of(bearings[3]);
    case (f.pair)
      btri_pkg::PAIR_12: begin
        t1 = tangent(q30_of(bearings[1]), bad);
        t2 = tangent(q30_of(bearings[2]), bad);
        den = t2 + t1;
        if (!bad && den != 0) begin
          px = (w * t2 * t1) / (den * 65536);
          py = (w * t1) / den;
          upd = 1;
        end
      end
      btri_pkg::PAIR_13: begin
        t1 = tangent(q30_of(bearings[1]), bad);
        if (a3 > longint'(btri_pkg::Q30_HALF_PI)) begin
          t3 = tangent(longint'(btri_pkg::Q30_PI) - a3, bad);
          num = h * t3 - w * t1 + l16;
          den = t3 - t1;
        end else begin
          t3 = tangent(a3, bad);
          num = h * t3 + w * t1 - l16;
          den = t1 + t3;
        end
        if (!bad && den != 0) begin
          py = num / den;
          px = ((w - py) * t1) / 65536;
          upd = 1;
        end
      end
      btri_pkg::PAIR_23: begin
        t2 = tangent(q30_of(bearings[2]), bad);
        if (a3 > longint'(btri_pkg::Q30_HALF_PI)) begin
          t3 = tangent(longint'(btri_pkg::Q30_PI) - a3, bad);
          num = l16 + h * t3;
          den = t2 + t3;
        end else begin
          t3 = tangent(a3, bad);
          num = h * t3 - l16;
          den = t3 - t2;
        end
        if (!bad && den != 0) begin
          py = num / den;
          px = (t2 * py) / 65536;
          upd = 1;
        end
      end
      default: ;
    endcase
    if (upd) begin
      held_x = clip16(px);
      held_y = clip16(py);
    end
    f.x = held_x;
    f.y = held_y;
    f.upd = upd;
    f.fault = (f.pair != btri_pkg::PAIR_NONE) && !upd;
    fix_q.push_back(f);
  endtask

  always @(posedge clk) begin
    fix_t e;
    if (rst) begin
      fix_q.delete();
      for (int i = 0; i < 4; i++) bearings[i] = '0;
      last_id = '0;
      prev_id = '0;
      held_x = '0;
      held_y = '0;
      tab_w = 13'd2000;
      tab_h = 13'd1000;
      tab_l = 13'd3000;
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (fix_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected position beat x=%0d y=%0d", x_position, y_position);
        end else begin
          e = fix_q.pop_front();
          if (x_position !== e.x || y_position !== e.y || position_updated !== e.upd ||
              pair_code !== e.pair || math_fault !== e.fault) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch exp x=%0d y=%0d upd=%0d pair=%0d fault=%0d, %s %0d %0d %0d %0d %0d",
                       e.x, e.y, e.upd, e.pair, e.fault, "got", x_position,
                       y_position, position_updated, pair_code, math_fault);
          end
        end
      end
      if (in_valid && in_ready) triangulate(beacon_id, bearing_angle);
      if (cfg_we) begin
        case (cfg_index)
          btri_pkg::REG_WIDTH:  tab_w = cfg_data;
          btri_pkg::REG_HALF:   tab_h = cfg_data;
          btri_pkg::REG_LENGTH: tab_l = cfg_data;
          default: ;
        endcase
      end
    end
    pending = fix_q.size();
  end

endmodule

@@ sim/beacon_pair_triangulation_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_pair_triangulation_test: top level of the triangulation bench
// drives bearing beats and table settings, stalls both channels in bursts
// and leaves prediction and comparison to the checker beside the block
// ----------------------------------------------------------------------------
module beacon_pair_triangulation_test;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [14:0] ANG_PI = 15'd25736;
  localparam logic [14:0] ANG_HALF = 15'd12868;
  localparam int CYCLE_LIMIT = 3000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         beacon_id = '0;
  logic [14:0]        bearing_angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] x_position, y_position;
  logic               position_updated, math_fault;
  logic [1:0]         pair_code;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [12:0]        cfg_data = '0;
  int                 fail_count, pending;
  int                 cycles = 0;
  bit                 calm = 0;       // no idling on either side
  bit                 hold_rx = 0;    // request for a long receiver stall

  always #6 clk = ~clk;

  beacon_pair_triangulation u_dut (.*);

  beacon_pair_triangulation_check u_check (.*);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("beacon_pair_triangulation_test: done, errors");
      $finish;
    end
  end

  // receiver: ready bursts, idle bursts, one long hold
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        // long stall counted here while the sender keeps offering beats;
        // longer than two full triangulations so the block surely fills
        repeat (1500) @(negedge clk);
        hold_rx = 0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one bearing beat; returns on the falling edge after acceptance
  task automatic send_bearing(input logic [1:0] id, input logic [14:0] ang);
    in_valid <= 1'b1;
    beacon_id <= id;
    bearing_angle <= ang;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 16);
      repeat (n) @(negedge clk);
    end
  endtask

  // drain every result, then let the block settle before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic table_setup(input logic [12:0] w, input logic [12:0] h, input logic [12:0] l);
    write_reg(btri_pkg::REG_WIDTH, w);
    write_reg(btri_pkg::REG_HALF, h);
    write_reg(btri_pkg::REG_LENGTH, l);
  endtask

  // mostly beacons 1 to 3 with useful bearings, some beacon 0 and raw angles
  task automatic random_bearing();
    logic [1:0]  id;
    logic [14:0] ang;
    id = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    case ($urandom_range(0, 9))
      0: ang = 15'($urandom);
      1: ang = ANG_HALF + 15'($urandom_range(0, 8)) - 15'd4;
      2: ang = ANG_PI - 15'($urandom_range(0, 3));
      default: ang = 15'($urandom_range(0, ANG_PI));
    endcase
    send_bearing(id, ang);
    sender_gap();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset tables, field extremes, every pair, faults
    send_bearing(2'd1, 15'd0);
    send_bearing(2'd2, 15'd0);          // zero divisor
    send_bearing(2'd1, 15'd6434);
    send_bearing(2'd2, 15'd6434);
    send_bearing(2'd3, 15'd19302);      // beacon 3 beyond pi/2
    send_bearing(2'd3, 15'd3000);       // same beacon again
    send_bearing(2'd2, 15'd9000);
    send_bearing(2'd3, ANG_HALF);       // tangent at pi/2
    send_bearing(2'd1, ANG_HALF);
    send_bearing(2'd0, 15'h7fff);       // unused beacon, above pi
    send_bearing(2'd3, 15'h7fff);       // beacon 0 with 3 gives no pair
    send_bearing(2'd1, 15'h7fff);
    send_bearing(2'd3, ANG_PI);
    send_bearing(2'd2, 15'h5555);
    send_bearing(2'd3, 15'h2aaa);
    send_bearing(2'd1, 15'd1);
    send_bearing(2'd2, ANG_PI);
    drain();

    // extreme tables, out of range index ignored
    table_setup(13'h1fff, 13'h1fff, 13'h1fff);
    write_reg(REG_SPARE, 13'h0123);
    send_bearing(2'd1, 15'd4000);
    send_bearing(2'd2, 15'd5000);
    send_bearing(2'd3, 15'd20000);
    send_bearing(2'd1, 15'd7000);
    send_bearing(2'd3, 15'd2000);
    drain();
    table_setup(13'd0, 13'd0, 13'd0);
    send_bearing(2'd2, 15'd5000);
    send_bearing(2'd3, 15'd20000);
    send_bearing(2'd1, 15'd3000);
    drain();

    // random phases under several table settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: table_setup(13'd2000, 13'd1000, 13'd3000);
        1: table_setup(13'($urandom), 13'($urandom), 13'($urandom));
        2: table_setup(13'h1fff, 13'd0, 13'h1fff);
        default: table_setup(13'($urandom), 13'($urandom), 13'($urandom));
      endcase
      if (ph == 3) calm = 1;
      for (int i = 0; i < 220; i++) begin
        if (ph == 1 && i == 40) hold_rx = 1;
        if (ph == 2 && i == 100) drain();   // sender pause until all results in
        random_bearing();
      end
      drain();
    end

    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("beacon_pair_triangulation_test: done, clean");
    else
      $display("beacon_pair_triangulation_test: done, errors");
    $finish;
  end

endmodule
